FILE: rtl/core/ftpr_pkg.sv
// ftpr_pkg: shared types and constants for the framed target packet receiver
// used by ftpr_circle, ftpr_code and framed_target_packet_receiver
package ftpr_pkg;

  // frame delimiters
  localparam logic [7:0] CIRCLE_HEAD = 8'hFF;
  localparam logic [7:0] CIRCLE_TAIL = 8'hFE;
  localparam logic [7:0] CODE_HEAD   = 8'hFA;
  localparam logic [7:0] CODE_TAIL   = 8'hAF;

  // circle frame layout
  localparam int unsigned CIRCLE_LEN = 8;
  localparam int unsigned SUM_LEN    = 6;
  localparam int unsigned CNT_W      = $clog2(CIRCLE_LEN) + 1;
  localparam int unsigned IDX_W      = $clog2(CIRCLE_LEN);
  localparam int unsigned SUM_W      = 11;

  // configuration register map
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_OFFSET = 1'b0,
    CFG_Y_OFFSET = 1'b1
  } cfg_reg_t;

  // reset values
  localparam logic [15:0] X_OFFSET_RST = 16'd320;
  localparam logic [15:0] Y_OFFSET_RST = 16'd240;
  localparam logic [15:0] HELD_XY_RST  = 16'd100;
  localparam logic [15:0] HELD_R_RST   = 16'd0;
  localparam logic [7:0]  HELD_CODE_RST = 8'd0;

  // circle event codes
  localparam logic [1:0] CEV_NONE   = 2'd0;
  localparam logic [1:0] CEV_ACCEPT = 2'd1;
  localparam logic [1:0] CEV_REJECT = 2'd2;

  // parser phases
  typedef enum logic [1:0] {
    CP_HEAD = 2'd0,
    CP_BODY = 2'd1,
    CP_TAIL = 2'd2
  } circle_phase_t;

  typedef enum logic [1:0] {
    QP_HEAD = 2'd0,
    QP_BYTE = 2'd1,
    QP_TAIL = 2'd2
  } code_phase_t;

  // per-byte outcome of the circle parser
  typedef struct packed {
    logic [1:0]  event_code;
    logic        load;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] radius;
  } circle_upd_t;

  // per-byte outcome of the code parser
  typedef struct packed {
    logic       load;
    logic [7:0] code;
  } code_upd_t;

endpackage

FILE: rtl/core/ftpr_circle.sv
// ftpr_circle: circle frame parser with its own payload store and checksum
// depends on ftpr_pkg
module ftpr_circle
  import ftpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_en,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] x_offset,
  input  logic [15:0] y_offset,
  output circle_upd_t upd
);

  circle_phase_t    phase_r, phase_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       payload_r [CIRCLE_LEN];
  logic [CNT_W-1:0] count_inc;
  logic [SUM_W-1:0] sum;
  logic [15:0]      check_word;
  logic             sum_ok;

  assign count_inc = count_r + CNT_W'(1);

  // next phase and byte count
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    unique case (phase_r)
      CP_HEAD: begin
        if (rx_byte == CIRCLE_HEAD) begin
          phase_nxt = CP_BODY;
          count_nxt = '0;
        end
      end
      CP_BODY: begin
        count_nxt = count_inc;
        if (count_inc >= CNT_W'(CIRCLE_LEN)) begin
          phase_nxt = CP_TAIL;
        end
      end
      CP_TAIL: phase_nxt = CP_HEAD;
      default: phase_nxt = CP_HEAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= CP_HEAD;
      count_r <= '0;
    end else if (byte_en) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  // payload store
  always_ff @(posedge clk) begin
    if (byte_en && phase_r == CP_BODY) begin
      payload_r[count_r[IDX_W-1:0]] <= rx_byte;
    end
  end

  // checksum over the first six payload bytes against the trailing word
  always_comb begin
    sum = '0;
    for (int i = 0; i < SUM_LEN; i++) begin
      sum = sum + SUM_W'(payload_r[i]);
    end
  end

  assign check_word = {payload_r[6], payload_r[7]};
  assign sum_ok     = ({{(16-SUM_W){1'b0}}, sum} == check_word);

  // frame outcome and latched values
  always_comb begin
    upd.event_code = CEV_NONE;
    upd.load       = 1'b0;
    upd.x          = {payload_r[0], payload_r[1]} - x_offset;
    upd.y          = {payload_r[2], payload_r[3]} - y_offset;
    upd.radius     = {payload_r[4], payload_r[5]};
    unique case (phase_r)
      CP_TAIL: begin
        if (rx_byte == CIRCLE_TAIL && sum_ok) begin
          upd.event_code = CEV_ACCEPT;
          upd.load       = 1'b1;
        end else begin
          upd.event_code = CEV_REJECT;
        end
      end
      default: upd.event_code = CEV_NONE;
    endcase
  end

endmodule

FILE: rtl/core/ftpr_code.sv
// ftpr_code: code frame parser, header, one byte, tail
// depends on ftpr_pkg
module ftpr_code
  import ftpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_en,
  input  logic [7:0] rx_byte,
  output code_upd_t  upd
);

  code_phase_t phase_r, phase_nxt;
  logic [7:0]  payload_r;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      QP_HEAD: begin
        if (rx_byte == CODE_HEAD) begin
          phase_nxt = QP_BYTE;
        end
      end
      QP_BYTE: phase_nxt = QP_TAIL;
      QP_TAIL: phase_nxt = QP_HEAD;
      default: phase_nxt = QP_HEAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= QP_HEAD;
    end else if (byte_en) begin
      phase_r <= phase_nxt;
    end
  end

  // code byte store
  always_ff @(posedge clk) begin
    if (byte_en && phase_r == QP_BYTE) begin
      payload_r <= rx_byte;
    end
  end

  // tail check
  always_comb begin
    upd.code = payload_r;
    upd.load = 1'b0;
    unique case (phase_r)
      QP_TAIL: upd.load = (rx_byte == CODE_TAIL);
      default: upd.load = 1'b0;
    endcase
  end

endmodule

FILE: rtl/core/framed_target_packet_receiver.sv
// framed_target_packet_receiver: top level, config registers and result register
// depends on ftpr_pkg, ftpr_circle, ftpr_code
//
//   channel | ports                                         | dir
//   --------+-----------------------------------------------+-----
//   input   | in_valid, in_stall, in_rx_byte                | in
//   result  | out_valid, out_stall, out_circle_event,       | out
//           | out_qr_event, out_target_x, out_target_y,     |
//           | out_target_radius, out_code_value             |
//   config  | cfg_we, cfg_index, cfg_wdata                  | in
//
// one byte per cycle while in_stall is low; a byte's result shows in the cycle after its transfer
// the result register is the only stage between the parsers and the output
// in_stall rises only while a result is held and the result side stalls
// synchronous active-low reset; no clearing pass, the block is ready at once
module framed_target_packet_receiver
  import ftpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_circle_event,
  output logic                  out_qr_event,
  output logic signed [15:0]    out_target_x,
  output logic signed [15:0]    out_target_y,
  output logic signed [15:0]    out_target_radius,
  output logic [7:0]            out_code_value,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic        in_xfer;
  logic        out_xfer;
  logic [15:0] x_offset_r;
  logic [15:0] y_offset_r;
  logic        out_valid_r;
  logic [1:0]  cev_r;
  logic        qev_r;
  logic [15:0] held_x_r, held_y_r, held_radius_r;
  logic [7:0]  held_code_r;
  circle_upd_t c_upd;
  code_upd_t   q_upd;

  // handshake
  assign in_stall = out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;
  assign out_xfer = out_valid_r & ~out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_offset_r <= X_OFFSET_RST;
      y_offset_r <= Y_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_X_OFFSET: x_offset_r <= cfg_wdata[15:0];
        CFG_Y_OFFSET: y_offset_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // parsers
  ftpr_circle u_circle (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_en  (in_xfer),
    .rx_byte  (in_rx_byte),
    .x_offset (x_offset_r),
    .y_offset (y_offset_r),
    .upd      (c_upd)
  );

  ftpr_code u_code (
    .clk     (clk),
    .rst_n   (rst_n),
    .byte_en (in_xfer),
    .rx_byte (in_rx_byte),
    .upd     (q_upd)
  );

  // result register, the held target values live here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      cev_r         <= CEV_NONE;
      qev_r         <= 1'b0;
      held_x_r      <= HELD_XY_RST;
      held_y_r      <= HELD_XY_RST;
      held_radius_r <= HELD_R_RST;
      held_code_r   <= HELD_CODE_RST;
    end else begin
      if (in_xfer) begin
        out_valid_r <= 1'b1;
        cev_r       <= c_upd.event_code;
        qev_r       <= q_upd.load;
        if (c_upd.load) begin
          held_x_r      <= c_upd.x;
          held_y_r      <= c_upd.y;
          held_radius_r <= c_upd.radius;
        end
        if (q_upd.load) begin
          held_code_r <= q_upd.code;
        end
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_circle_event  = cev_r;
  assign out_qr_event      = qev_r;
  assign out_target_x      = $signed(held_x_r);
  assign out_target_y      = $signed(held_y_r);
  assign out_target_radius = $signed(held_radius_r);
  assign out_code_value    = held_code_r;

  // every byte transfer leaves a result behind
  a_xfer_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("byte transfer produced no result");

  // target values only move on an accepted circle frame
  a_target_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && c_upd.event_code != CEV_ACCEPT) |=>
      ($stable(held_x_r) && $stable(held_y_r) && $stable(held_radius_r)))
    else $error("target values changed without an accepted frame");

  // code value only moves on a completed code frame
  a_code_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !q_upd.load) |=> $stable(held_code_r))
    else $error("code value changed without a completed frame");

  // the circle parser never reports an undefined event code
  a_cev_legal : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (cev_r == CEV_NONE || cev_r == CEV_ACCEPT || cev_r == CEV_REJECT))
    else $error("undefined circle event code");

endmodule

FILE: dv/tb_top.sv
// tb_top: self-checking testbench for framed_target_packet_receiver
// depends on ftpr_pkg and the receiver rtl; byte driver, result monitor and frame predictor
`timescale 1ns / 100ps

module tb_top
  import ftpr_pkg::*;
;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;

  typedef struct {
    logic [1:0]         circle_event;
    logic               qr_event;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] radius;
    logic [7:0]         code;
  } frame_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_rx_byte = 8'h00;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_circle_event;
  logic                  out_qr_event;
  logic signed [15:0]    out_target_x;
  logic signed [15:0]    out_target_y;
  logic signed [15:0]    out_target_radius;
  logic [7:0]            out_code_value;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_X_OFFSET;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // byte stream waiting to be sent and results still owed by the block
  logic [7:0]    rx_bytes_q[$];
  frame_result_t expected_results[$];
  int            bytes_queued = 0;
  int            bytes_sent = 0;
  int            results_seen = 0;
  int            err_count = 0;
  int            cycle_count = 0;
  int            gap_left = 0;
  int            stall_left = 0;
  int            hold_left = 0;
  bit            calm = 1'b0;

  // predictor state
  logic [15:0]   pred_x_off;
  logic [15:0]   pred_y_off;
  circle_phase_t circ_phase;
  logic [3:0]    circ_cnt;
  logic [7:0]    circ_buf[8];
  code_phase_t   code_phase;
  logic [7:0]    code_byte;
  logic [15:0]   held_x;
  logic [15:0]   held_y;
  logic [15:0]   held_radius;
  logic [7:0]    held_code;

  framed_target_packet_receiver dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_circle_event  (out_circle_event),
    .out_qr_event      (out_qr_event),
    .out_target_x      (out_target_x),
    .out_target_y      (out_target_y),
    .out_target_radius (out_target_radius),
    .out_code_value    (out_code_value),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic clear_predictor();
    pred_x_off  = X_OFFSET_RST;
    pred_y_off  = Y_OFFSET_RST;
    circ_phase  = CP_HEAD;
    circ_cnt    = '0;
    for (int i = 0; i < 8; i++) circ_buf[i] = '0;
    code_phase  = QP_HEAD;
    code_byte   = '0;
    held_x      = HELD_XY_RST;
    held_y      = HELD_XY_RST;
    held_radius = HELD_R_RST;
    held_code   = HELD_CODE_RST;
  endtask

  // run one byte through both frame parsers, return the result it yields
  function automatic frame_result_t parse_byte(input logic [7:0] b);
    frame_result_t res;
    logic [15:0]   sum;
    res.circle_event = CEV_NONE;
    res.qr_event     = 1'b0;
    // circle frame parser
    case (circ_phase)
      CP_BODY: begin
        circ_buf[circ_cnt[2:0]] = b;
        circ_cnt = circ_cnt + 4'd1;
        if (circ_cnt >= CIRCLE_LEN) circ_phase = CP_TAIL;
      end
      CP_TAIL: begin
        res.circle_event = CEV_REJECT;
        if (b == CIRCLE_TAIL) begin
          sum = '0;
          for (int i = 0; i < SUM_LEN; i++) sum = sum + 16'(circ_buf[i]);
          if (sum == {circ_buf[6], circ_buf[7]}) begin
            held_x      = {circ_buf[0], circ_buf[1]} - pred_x_off;
            held_y      = {circ_buf[2], circ_buf[3]} - pred_y_off;
            held_radius = {circ_buf[4], circ_buf[5]};
            res.circle_event = CEV_ACCEPT;
          end
        end
        circ_phase = CP_HEAD;
      end
      CP_HEAD: begin
        if (b == CIRCLE_HEAD) begin
          circ_phase = CP_BODY;
          circ_cnt   = '0;
        end
      end
      default: circ_phase = CP_HEAD;
    endcase
    // code frame parser
    case (code_phase)
      QP_BYTE: begin
        code_byte  = b;
        code_phase = QP_TAIL;
      end
      QP_TAIL: begin
        if (b == CODE_TAIL) begin
          held_code    = code_byte;
          res.qr_event = 1'b1;
        end
        code_phase = QP_HEAD;
      end
      QP_HEAD: begin
        if (b == CODE_HEAD) code_phase = QP_BYTE;
      end
      default: code_phase = QP_HEAD;
    endcase
    res.x      = held_x;
    res.y      = held_y;
    res.radius = held_radius;
    res.code   = held_code;
    return res;
  endfunction

  // byte driver: offers queued bytes, random idle bursts between transfers
  always @(posedge clk) begin : byte_driver
    logic       nxt_valid;
    logic [7:0] nxt_byte;
    nxt_valid = in_valid;
    nxt_byte  = in_rx_byte;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(parse_byte(in_rx_byte));
        bytes_sent++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(1, 14) - 1;
        end else if (rx_bytes_q.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_byte  = rx_bytes_q.pop_front();
        end
      end
    end
    in_valid   <= nxt_valid;
    in_rx_byte <= nxt_byte;
  end

  // result monitor: checks each transfer, drives random stall bursts
  always @(posedge clk) begin : result_monitor
    frame_result_t exp_r;
    logic          nxt_stall;
    nxt_stall = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          err_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_circle_event !== exp_r.circle_event) begin
            $error("circle_event mismatch: expected %0d, actual %0d",
                   exp_r.circle_event, out_circle_event);
            err_count++;
          end
          if (out_qr_event !== exp_r.qr_event) begin
            $error("qr_event mismatch: expected %0d, actual %0d",
                   exp_r.qr_event, out_qr_event);
            err_count++;
          end
          if (out_target_x !== exp_r.x) begin
            $error("target_x mismatch: expected %0d, actual %0d", exp_r.x, out_target_x);
            err_count++;
          end
          if (out_target_y !== exp_r.y) begin
            $error("target_y mismatch: expected %0d, actual %0d", exp_r.y, out_target_y);
            err_count++;
          end
          if (out_target_radius !== exp_r.radius) begin
            $error("target_radius mismatch: expected %0d, actual %0d",
                   exp_r.radius, out_target_radius);
            err_count++;
          end
          if (out_code_value !== exp_r.code) begin
            $error("code_value mismatch: expected %0d, actual %0d",
                   exp_r.code, out_code_value);
            err_count++;
          end
        end
        // long hold-off so the block backs up into its input
        if (results_seen == 250 || results_seen == 550) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_stall = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_stall = 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        nxt_stall  = 1'b1;
      end
    end
    out_stall <= nxt_stall;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b);
    rx_bytes_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_circle_frame(input logic [15:0] x, input logic [15:0] y,
                                    input logic [15:0] r, input bit bad_sum,
                                    input logic [7:0] tail);
    logic [15:0] sum;
    sum = 16'(x[15:8]) + 16'(x[7:0]) + 16'(y[15:8]) + 16'(y[7:0])
        + 16'(r[15:8]) + 16'(r[7:0]);
    if (bad_sum) sum = sum ^ (16'd1 << $urandom_range(0, 15));
    queue_byte(CIRCLE_HEAD);
    queue_byte(x[15:8]);
    queue_byte(x[7:0]);
    queue_byte(y[15:8]);
    queue_byte(y[7:0]);
    queue_byte(r[15:8]);
    queue_byte(r[7:0]);
    queue_byte(sum[15:8]);
    queue_byte(sum[7:0]);
    queue_byte(tail);
  endtask

  task automatic queue_code_frame(input logic [7:0] code, input logic [7:0] tail);
    queue_byte(CODE_HEAD);
    queue_byte(code);
    queue_byte(tail);
  endtask

  // mostly well-formed frames with random content, some broken ones and noise
  task automatic queue_random_traffic(input int n);
    int          start;
    int          kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] r;
    logic [7:0]  tail;
    start = bytes_queued;
    while (bytes_queued - start < n) begin
      kind = $urandom_range(0, 19);
      if (kind <= 9) begin
        x = 16'($urandom);
        y = 16'($urandom);
        r = 16'($urandom);
        // all-ones payload gives the largest checksum
        if (kind == 9) begin
          x = 16'hFFFF;
          y = 16'hFFFF;
          r = 16'hFFFF;
        end
        tail = ($urandom_range(0, 7) == 0) ? 8'($urandom) : CIRCLE_TAIL;
        queue_circle_frame(x, y, r, $urandom_range(0, 5) == 0, tail);
      end else if (kind <= 15) begin
        tail = ($urandom_range(0, 5) == 0) ? 8'($urandom) : CODE_TAIL;
        queue_code_frame(8'($urandom), tail);
      end else if (kind <= 17) begin
        // truncated frame
        queue_byte(kind == 16 ? CIRCLE_HEAD : CODE_HEAD);
        repeat ($urandom_range(1, 5)) queue_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (!(bytes_sent == bytes_queued && expected_results.size() == 0));
    repeat (3) @(posedge clk);
  endtask

  // offsets change only while the block is empty
  task automatic write_offsets(input logic [15:0] x_off, input logic [15:0] y_off);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_X_OFFSET;
    cfg_wdata <= x_off;
    @(posedge clk);
    cfg_index <= CFG_Y_OFFSET;
    cfg_wdata <= y_off;
    @(posedge clk);
    cfg_we     <= 1'b0;
    pred_x_off = x_off;
    pred_y_off = y_off;
  endtask

  initial begin
    clear_predictor();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // good circle frame that also carries a complete code frame in its payload
    queue_circle_frame(16'hFA5A, 16'hAF00, 16'hFFFF, 1'b0, CIRCLE_TAIL);
    // code frame with a header byte as tail, then bytes that would complete
    // a frame only if that tail were taken as a new header
    queue_code_frame(8'h00, CODE_HEAD);
    queue_byte(8'h00);
    queue_byte(CODE_TAIL);
    // zero circle frame ended by a header byte instead of its tail
    queue_circle_frame(16'h0000, 16'h0000, 16'h0000, 1'b0, CIRCLE_HEAD);
    queue_random_traffic(150);

    write_offsets(16'h0000, 16'h0000);
    queue_random_traffic(200);
    write_offsets(16'hFFFF, 16'hFFFF);
    queue_random_traffic(200);
    write_offsets(16'($urandom), 16'($urandom));
    queue_random_traffic(150);

    // last part runs without idling on either side
    write_offsets(16'h8000, 16'h7FFF);
    calm = 1'b1;
    queue_random_traffic(100);

    wait_drained();
    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
